### sv/rfbd_pkg.sv
package rfbd_pkg;

  typedef struct packed {
    logic signed [15:0] sample_i;
    logic signed [15:0] sample_q;
  } in_t;

  typedef struct packed {
    logic [2:0]  event_res;
    logic [47:0] sample_index;
    logic [31:0] offset_in_burst;
    logic [31:0] event_length;
    logic [7:0]  kept_sub_count;
    logic [47:0] magnitude_sum;
    logic [31:0] active_samples;
    logic [15:0] noise_floor_out;
    logic [23:0] threshold_out;
  } out_t;

  localparam int DefIndexWidth = 48;

  // configuration register indexes
  localparam logic [2:0] CFG_THRESHOLD_FACTOR = 3'd0;
  localparam logic [2:0] CFG_NOISE_WINDOW     = 3'd1;
  localparam logic [2:0] CFG_MIN_SAMPLES      = 3'd2;
  localparam logic [2:0] CFG_QUIET_SAMPLES    = 3'd3;
  localparam logic [2:0] CFG_COALESCE_SAMPLES = 3'd4;

  localparam logic [7:0]  RST_THRESHOLD_FACTOR = 8'd8;
  localparam logic [15:0] RST_NOISE_WINDOW     = 16'd1000;
  localparam logic [15:0] RST_MIN_SAMPLES      = 16'd150;
  localparam logic [15:0] RST_QUIET_SAMPLES    = 16'd20;
  localparam logic [23:0] RST_COALESCE_SAMPLES = 24'd10000;
  localparam logic [23:0] RST_THRESHOLD        = 24'd100000;

  // receiver modes
  localparam logic [1:0] MODE_LISTEN   = 2'd0;
  localparam logic [1:0] MODE_COALESCE = 2'd1;
  localparam logic [1:0] MODE_RX       = 2'd2;

  // events
  localparam logic [2:0] EV_BURST_START = 3'd0;
  localparam logic [2:0] EV_SUB_START   = 3'd1;
  localparam logic [2:0] EV_SUB_STOP    = 3'd2;
  localparam logic [2:0] EV_SUB_CANCEL  = 3'd3;
  localparam logic [2:0] EV_BURST_DONE  = 3'd4;
  localparam logic [2:0] EV_BURST_DROP  = 3'd5;

  // datapath operations
  localparam logic [3:0] OP_NONE  = 4'd0;
  localparam logic [3:0] OP_LOAD  = 4'd1;
  localparam logic [3:0] OP_SQI   = 4'd2;
  localparam logic [3:0] OP_SQQ   = 4'd3;
  localparam logic [3:0] OP_ROOT  = 4'd4;
  localparam logic [3:0] OP_ACC   = 4'd5;
  localparam logic [3:0] OP_DIV   = 4'd6;
  localparam logic [3:0] OP_FLOOR = 4'd7;
  localparam logic [3:0] OP_BURST = 4'd8;

  typedef struct packed {
    logic [3:0] op;
  } cmd_t;

  typedef struct packed {
    logic root_last;
    logic div_last;
    logic win_full;
    logic out_busy;
  } sts_t;

endpackage

### sv/rfbd_ctrl.sv
module rfbd_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  rfbd_pkg::sts_t sts,
  output rfbd_pkg::cmd_t cmd
);
  import rfbd_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SQI   = 3'd1;
  localparam logic [2:0] S_SQQ   = 3'd2;
  localparam logic [2:0] S_ROOT  = 3'd3;
  localparam logic [2:0] S_ACC   = 3'd4;
  localparam logic [2:0] S_DIV   = 3'd5;
  localparam logic [2:0] S_FLOOR = 3'd6;
  localparam logic [2:0] S_BURST = 3'd7;

  logic [2:0] state, state_next;

  assign in_stall = (state != S_IDLE);

  always_comb begin
    state_next = state;
    cmd.op = OP_NONE;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op = OP_LOAD;
          state_next = S_SQI;
        end
      end
      S_SQI: begin
        cmd.op = OP_SQI;
        state_next = S_SQQ;
      end
      S_SQQ: begin
        cmd.op = OP_SQQ;
        state_next = S_ROOT;
      end
      S_ROOT: begin
        cmd.op = OP_ROOT;
        if (sts.root_last) state_next = S_ACC;
      end
      S_ACC: begin
        cmd.op = OP_ACC;
        state_next = sts.win_full ? S_DIV : S_BURST;
      end
      S_DIV: begin
        cmd.op = OP_DIV;
        if (sts.div_last) state_next = S_FLOOR;
      end
      S_FLOOR: begin
        cmd.op = OP_FLOOR;
        state_next = S_BURST;
      end
      S_BURST: begin
        // hold until the output register can take a result
        if (!sts.out_busy) begin
          cmd.op = OP_BURST;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

endmodule

### sv/rfbd_dp.sv
module rfbd_dp #(
  parameter int IndexWidth = rfbd_pkg::DefIndexWidth
) (
  input  logic           clk,
  input  logic           rst,
  input  rfbd_pkg::in_t  in_data,
  input  rfbd_pkg::cmd_t cmd,
  output rfbd_pkg::sts_t sts,
  input  logic           cfg_valid,
  input  logic [2:0]     cfg_index,
  input  logic [23:0]    cfg_data,
  output logic           out_valid,
  input  logic           out_stall,
  output rfbd_pkg::out_t out_data
);
  import rfbd_pkg::*;

  // configuration
  logic [7:0]  threshold_factor;
  logic [15:0] noise_window, min_samples, quiet_samples;
  logic [23:0] coalesce_samples;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold_factor <= RST_THRESHOLD_FACTOR;
      noise_window     <= RST_NOISE_WINDOW;
      min_samples      <= RST_MIN_SAMPLES;
      quiet_samples    <= RST_QUIET_SAMPLES;
      coalesce_samples <= RST_COALESCE_SAMPLES;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_THRESHOLD_FACTOR: threshold_factor <= cfg_data[7:0];
        CFG_NOISE_WINDOW:     noise_window     <= cfg_data[15:0];
        CFG_MIN_SAMPLES:      min_samples      <= cfg_data[15:0];
        CFG_QUIET_SAMPLES:    quiet_samples    <= cfg_data[15:0];
        CFG_COALESCE_SAMPLES: coalesce_samples <= cfg_data;
        default: ;
      endcase
    end
  end

  logic [15:0] win, quiet;
  assign win   = (noise_window == '0) ? 16'd1 : noise_window;
  assign quiet = (quiet_samples == '0) ? 16'd1 : quiet_samples;

  // magnitude: squares, then a bit-pair-per-cycle square root
  logic [16:0] abs_i, abs_q;
  logic [31:0] sq_v, sq_r, sq_b, sq_rb;
  logic [4:0]  step;
  logic [15:0] mag;

  assign sq_rb = sq_r + sq_b;

  // window averaging with a restoring divider
  logic [31:0] window_sum, sum_new, quo;
  logic [15:0] window_count, cnt_new;
  logic [16:0] rem, rem_s;
  logic        floor_valid;
  logic [15:0] noise_floor;
  logic [23:0] detect_threshold;

  assign sum_new = window_sum + {16'd0, mag};
  assign cnt_new = window_count + 16'd1;
  assign rem_s   = {rem[15:0], quo[31]};

  assign sts.root_last = (step == 5'd15);
  assign sts.div_last  = (step == 5'd31);
  assign sts.win_full  = (cnt_new >= win);
  assign sts.out_busy  = out_valid && out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_sum       <= '0;
      window_count     <= '0;
      floor_valid      <= 1'b0;
      noise_floor      <= '0;
      detect_threshold <= RST_THRESHOLD;
    end else begin
      case (cmd.op)
        OP_LOAD: begin
          abs_i <= in_data.sample_i[15] ? (17'h10000 - {1'b0, in_data.sample_i})
                                        : {1'b0, in_data.sample_i};
          abs_q <= in_data.sample_q[15] ? (17'h10000 - {1'b0, in_data.sample_q})
                                        : {1'b0, in_data.sample_q};
        end
        OP_SQI: sq_v <= {15'd0, abs_i} * {15'd0, abs_i};
        OP_SQQ: begin
          sq_v <= sq_v + ({15'd0, abs_q} * {15'd0, abs_q});
          sq_r <= '0;
          sq_b <= 32'h4000_0000;
          step <= '0;
        end
        OP_ROOT: begin
          if (sq_v >= sq_rb) begin
            sq_v <= sq_v - sq_rb;
            sq_r <= (sq_r >> 1) + sq_b;
          end else begin
            sq_r <= sq_r >> 1;
          end
          sq_b <= sq_b >> 2;
          step <= step + 5'd1;
          if (sts.root_last) mag <= (sq_v >= sq_rb) ? 16'((sq_r >> 1) + sq_b)
                                                    : 16'(sq_r >> 1);
        end
        OP_ACC: begin
          if (sts.win_full) begin
            window_sum   <= '0;
            window_count <= '0;
            quo          <= sum_new;
            rem          <= '0;
            step         <= '0;
          end else begin
            window_sum   <= sum_new;
            window_count <= cnt_new;
          end
        end
        OP_DIV: begin
          if (rem_s >= {1'b0, win}) begin
            rem <= rem_s - {1'b0, win};
            quo <= {quo[30:0], 1'b1};
          end else begin
            rem <= rem_s;
            quo <= {quo[30:0], 1'b0};
          end
          step <= step + 5'd1;
        end
        OP_FLOOR: begin
          if (!floor_valid || quo < {16'd0, noise_floor}) begin
            noise_floor      <= quo[15:0];
            floor_valid      <= 1'b1;
            detect_threshold <= {8'd0, quo[15:0]} * {16'd0, threshold_factor};
          end
        end
        default: ;
      endcase
    end
  end

  // burst tracking
  logic [1:0]  rx_mode;
  logic [23:0] under_count;
  logic [31:0] burst_samples, burst_position, sub_samples, sub_start_offset;
  logic [31:0] first_kept_start, last_kept_end;
  logic [7:0]  kept_subs;
  logic [47:0] mag_acc;
  logic [IndexWidth-1:0] sample_counter;

  logic [1:0]  mode_n;
  logic [23:0] uc_n;
  logic [31:0] bs_n, bp_n, ss_n, sso_n, fks_n, lke_n, end_off, ev_off, ev_len;
  logic [7:0]  kept_n;
  logic [48:0] acc_sum;
  logic [47:0] acc_n;
  logic        ev_hit;
  logic [2:0]  ev;

  always_comb begin
    mode_n = rx_mode;
    uc_n   = under_count;
    bs_n   = burst_samples;
    bp_n   = burst_position;
    ss_n   = sub_samples;
    sso_n  = sub_start_offset;
    fks_n  = first_kept_start;
    lke_n  = last_kept_end;
    kept_n = kept_subs;
    acc_n  = mag_acc;
    ev_hit = 1'b0;
    ev     = EV_BURST_START;
    ev_off = '0;
    ev_len = '0;
    end_off = '0;
    acc_sum = '0;

    if ({8'd0, mag} >= detect_threshold) begin
      if (rx_mode == MODE_LISTEN) begin
        mode_n = MODE_RX;
        bp_n = '0; bs_n = '0; kept_n = '0; acc_n = '0;
        ss_n = '0; sso_n = '0; fks_n = '0; lke_n = '0;
        ev_hit = 1'b1;
        ev = EV_BURST_START;
      end else if (rx_mode == MODE_COALESCE) begin
        mode_n = MODE_RX;
        sso_n = burst_position;
        ss_n = '0;
        ev_hit = 1'b1;
        ev = EV_SUB_START;
        ev_off = burst_position;
      end
      uc_n = '0;
    end else if (under_count != 24'hFF_FFFF) begin
      uc_n = under_count + 24'd1;
    end

    if (mode_n != MODE_LISTEN) begin
      if (bs_n != 32'hFFFF_FFFF) bs_n = bs_n + 32'd1;
      if (mode_n == MODE_RX) begin
        acc_sum = {1'b0, acc_n} + {33'd0, mag};
        acc_n = acc_sum[48] ? 48'hFFFF_FFFF_FFFF : acc_sum[47:0];
        if (ss_n != 32'hFFFF_FFFF) ss_n = ss_n + 32'd1;
        if (uc_n >= {8'd0, quiet}) begin
          if (ss_n >= {16'd0, min_samples}) begin
            end_off = (bp_n > {16'd0, quiet}) ? bp_n - {16'd0, quiet} : '0;
            if (end_off < sso_n) end_off = sso_n;
            if (kept_n == '0) fks_n = sso_n;
            lke_n = end_off;
            if (kept_n != 8'hFF) kept_n = kept_n + 8'd1;
            uc_n = '0;
            ev_hit = 1'b1;
            ev = EV_SUB_STOP;
            ev_off = end_off;
            ev_len = end_off - sso_n;
          end else begin
            ev_hit = 1'b1;
            ev = EV_SUB_CANCEL;
            ev_off = sso_n;
          end
          mode_n = MODE_COALESCE;
        end
      end else if (uc_n >= coalesce_samples) begin
        mode_n = MODE_LISTEN;
        ev_hit = 1'b1;
        if (bs_n >= {16'd0, min_samples} && kept_n != '0) begin
          ev = EV_BURST_DONE;
          ev_off = fks_n;
          ev_len = (lke_n > fks_n) ? lke_n - fks_n : '0;
        end else begin
          ev = EV_BURST_DROP;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rx_mode          <= MODE_LISTEN;
      under_count      <= '0;
      burst_samples    <= '0;
      burst_position   <= '0;
      sub_samples      <= '0;
      sub_start_offset <= '0;
      first_kept_start <= '0;
      last_kept_end    <= '0;
      kept_subs        <= '0;
      mag_acc          <= '0;
      sample_counter   <= '0;
      out_valid        <= 1'b0;
    end else begin
      if (cmd.op == OP_BURST && ev_hit) out_valid <= 1'b1;
      else if (out_valid && !out_stall) out_valid <= 1'b0;
      if (cmd.op == OP_BURST) begin
        rx_mode          <= mode_n;
        under_count      <= uc_n;
        burst_samples    <= bs_n;
        burst_position   <= (mode_n != MODE_LISTEN && bp_n != 32'hFFFF_FFFF)
                            ? bp_n + 32'd1 : bp_n;
        sub_samples      <= ss_n;
        sub_start_offset <= sso_n;
        first_kept_start <= fks_n;
        last_kept_end    <= lke_n;
        kept_subs        <= kept_n;
        mag_acc          <= acc_n;
        sample_counter   <= sample_counter + {{(IndexWidth-1){1'b0}}, 1'b1};
        if (ev_hit) begin
          out_data.event_res       <= ev;
          out_data.sample_index    <= 48'(sample_counter);
          out_data.offset_in_burst <= ev_off;
          out_data.event_length    <= ev_len;
          out_data.kept_sub_count  <= kept_n;
          out_data.magnitude_sum   <= acc_n;
          out_data.active_samples  <= bs_n;
          out_data.noise_floor_out <= noise_floor;
          out_data.threshold_out   <= detect_threshold;
        end
      end
    end
  end

endmodule

### sv/rf_burst_detector.sv
// Energy burst detector with an adaptive noise floor.
// Input channel (in_valid / in_stall / in_data) takes one complex I/Q sample
// per transfer. Output channel (out_valid / out_stall / out_data) gives at
// most one event per sample: burst start, sub-burst start/stop/cancel,
// burst done or burst dropped, with offsets, lengths, magnitude sum and the
// current noise floor and threshold.
// Configuration: cfg_valid / cfg_ready / cfg_index / cfg_data; cfg_ready is
// always high, writes should be made while no sample is in flight.
// Each sample steps through the transfer cycle with the operand load, the
// I and Q squares, the square root (two bits per cycle), the window sum
// and the burst update, which writes any event into the output register.
// A sample that closes a noise window adds the bit-serial divide and the
// floor update.
// in_stall is high from a transfer until the sample is fully processed.
// A result sits in the output register; while out_stall holds it, the
// next sample runs up to its burst update and waits there.
// Synchronous reset restores the register defaults, the listen state and
// a threshold of 100000.
module rf_burst_detector #(
  parameter int IndexWidth = rfbd_pkg::DefIndexWidth
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  rfbd_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output rfbd_pkg::out_t out_data,
  input  logic           cfg_valid,
  output logic           cfg_ready,
  input  logic [2:0]     cfg_index,
  input  logic [23:0]    cfg_data
);
  import rfbd_pkg::*;

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  rfbd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  rfbd_dp #(.IndexWidth(IndexWidth)) u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

`ifndef SYNTH
  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("no stall after sample transfer");

  a_result_in_work: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared with no sample in work");
`endif

endmodule
